// ===== hdl/htwd_pkg.sv =====
// shared types and constants for the huffman tree walk decoder
// no dependencies; used by the channel interfaces and the top level
`timescale 1ns / 1ps

package htwd_pkg;

   localparam int IDX_W     = 9;
   localparam int SYM_W     = 8;
   localparam int PAD_W     = 3;
   localparam int BYTE_BITS = 8;
   localparam int CNT_W     = 4;

   // request kinds
   localparam logic REQ_NODE = 1'b0;
   localparam logic REQ_DATA = 1'b1;

   // register indexes (word address bit 2)
   localparam logic REG_ROOT = 1'b0;
   localparam logic REG_PAD  = 1'b1;

   // one tree node as held in the node store
   typedef struct packed {
      logic             leaf;
      logic [IDX_W-1:0] child_l;
      logic [IDX_W-1:0] child_r;
      logic [SYM_W-1:0] sym;
   } node_type;

   localparam int NODE_W = $bits(node_type);

endpackage

// ===== hdl/htwd_if.sv =====
// valid/ready channel interfaces for requests and decoded symbols
// depends on htwd_pkg
`timescale 1ns / 1ps

interface htwd_req_if;
   import htwd_pkg::*;

   logic             valid;
   logic             ready;
   logic             req_type;
   logic [IDX_W-1:0] node_index;
   logic             node_is_leaf;
   logic [IDX_W-1:0] node_left;
   logic [IDX_W-1:0] node_right;
   logic [SYM_W-1:0] node_symbol;
   logic [SYM_W-1:0] data_byte;
   logic             final_byte;

   modport source (
      output valid, req_type, node_index, node_is_leaf, node_left, node_right,
             node_symbol, data_byte, final_byte,
      input  ready
   );
   modport sink (
      input  valid, req_type, node_index, node_is_leaf, node_left, node_right,
             node_symbol, data_byte, final_byte,
      output ready
   );
endinterface

interface htwd_rsp_if;
   import htwd_pkg::*;

   logic             valid;
   logic             ready;
   logic [SYM_W-1:0] symbol;
   logic             last_of_run;

   modport source (output valid, symbol, last_of_run, input ready);
   modport sink (input valid, symbol, last_of_run, output ready);
endinterface

// ===== hdl/htwd_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module htwd_ram #(
   parameter int WIDTH = 27,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== hdl/huffman_tree_walk_decoder.sv =====
// huffman tree walk decoder top level: node store, walk sequencer, csr port
// depends on htwd_pkg, htwd_if (req/rsp channels) and htwd_ram
`timescale 1ns / 1ps

// Usage:
//  req_chan takes two kinds of transaction. A node write (req_type 0) stores
//  leaf flag, children and symbol at node_index. A data
//  transaction (req_type 1) carries one compressed byte that is walked MSB
//  first from the current walk position, 0 to the left child, 1 to the right.
//  Each leaf reached gives one rsp_chan transaction with its symbol; the last
//  symbol of a byte carries last_of_run. On final_byte, pad_bits trailing bits
//  are skipped and the walk goes back to root_index.
//  Each walked bit is a step of the walk, and so is each leaf reached by a
//  step (a leaf met at the start of a bit shares that bit's step); a closing
//  step ends the byte. req_chan is ready only between bytes, so the next
//  transaction is taken only once the closing step is done. The symbol of
//  each leaf is held one step so that the last one can be marked; it reaches
//  rsp_chan when the next symbol or the end of the byte arrives.
//  A stalled rsp_chan holds the output register and halts the walk once a
//  second symbol is waiting. Reset clears root_index, pad_bits, the walk
//  position and the output register; the node store must be written before
//  it is walked. Writing root_index also moves the walk to the new root.

module huffman_tree_walk_decoder #(
   parameter int NODE_COUNT = 512
) (
   input  logic                      clock,
   input  logic                      reset,
   htwd_req_if.sink                  req_chan,
   htwd_rsp_if.source                rsp_chan,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [2:0]                csr_paddr,
   input  logic [31:0]               csr_pwdata,
   output logic [31:0]               csr_prdata,
   output logic                      csr_pready
);
   import htwd_pkg::*;

   localparam int AW = $clog2(NODE_COUNT);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_WALK = 1'b1;

   logic             state_ff, state_in;
   logic [IDX_W-1:0] cur_ff, cur_in;
   logic             mode_b_ff, mode_b_in;
   logic [CNT_W-1:0] bits_ff, bits_in;
   logic [7:0]       shreg_ff, shreg_in;
   logic             fin_ff, fin_in;
   logic             hold_ff, hold_in;
   logic [SYM_W-1:0] hold_sym_ff, hold_sym_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [SYM_W-1:0] rsp_sym_ff, rsp_sym_in;
   logic             rsp_last_ff, rsp_last_in;
   logic [IDX_W-1:0] root_ff, root_in;
   logic [PAD_W-1:0] pad_ff, pad_in;
   logic             oor_ff, oor_in;

   logic             csr_wr;
   logic             req_acc;
   logic             node_we;
   node_type         wr_node;
   logic [NODE_W-1:0] ram_rdata;
   node_type         entry;
   logic             slot_free;
   logic             emit;
   logic             finish;
   logic             step;
   logic             stall;

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      case (csr_paddr[2])
         REG_ROOT: csr_prdata = {{(32-IDX_W){1'b0}}, root_ff};
         REG_PAD:  csr_prdata = {{(32-PAD_W){1'b0}}, pad_ff};
         default:  csr_prdata = '0;
      endcase
   end

   // request acceptance and node writes
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_acc        = req_chan.valid && req_chan.ready;
   assign node_we        = req_acc && (req_chan.req_type == REQ_NODE) &&
                           (32'(req_chan.node_index) < NODE_COUNT);

   assign wr_node.leaf    = req_chan.node_is_leaf;
   assign wr_node.child_l = req_chan.node_left;
   assign wr_node.child_r = req_chan.node_right;
   assign wr_node.sym     = req_chan.node_symbol;

   // node store, read address follows the next walk position
   htwd_ram #(
      .WIDTH (NODE_W),
      .DEPTH (NODE_COUNT)
   ) u_store (
      .clock (clock),
      .we    (node_we),
      .waddr (AW'(32'(req_chan.node_index))),
      .wdata (wr_node),
      .raddr (AW'(32'(cur_in))),
      .rdata (ram_rdata)
   );

   // indexes past the store read as an empty inner node
   assign entry     = oor_ff ? '0 : node_type'(ram_rdata);
   assign oor_in    = (32'(cur_in) >= NODE_COUNT);
   assign slot_free = !rsp_valid_ff || rsp_chan.ready;

   // walk decision for the current node
   always_comb begin
      emit   = 1'b0;
      finish = 1'b0;
      step   = 1'b0;
      if (!mode_b_ff) begin
         if (bits_ff == '0) begin
            finish = 1'b1;
         end else if (entry.leaf) begin
            emit = 1'b1;
         end else begin
            step = 1'b1;
         end
      end else begin
         if (entry.leaf) begin
            emit = 1'b1;
         end else if (bits_ff == '0) begin
            finish = 1'b1;
         end else begin
            step = 1'b1;
         end
      end
      stall = (state_ff == ST_WALK) && (emit || finish) && hold_ff && !slot_free;
   end

   // sequencer next state
   always_comb begin
      state_in    = state_ff;
      cur_in      = cur_ff;
      mode_b_in   = mode_b_ff;
      bits_in     = bits_ff;
      shreg_in    = shreg_ff;
      fin_in      = fin_ff;
      hold_in     = hold_ff;
      hold_sym_in = hold_sym_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_sym_in  = rsp_sym_ff;
      rsp_last_in = rsp_last_ff;
      root_in     = root_ff;
      pad_in      = pad_ff;

      case (state_ff)
         ST_IDLE: begin
            if (csr_wr) begin
               case (csr_paddr[2])
                  REG_ROOT: begin
                     root_in = csr_pwdata[IDX_W-1:0];
                     cur_in  = csr_pwdata[IDX_W-1:0];
                  end
                  REG_PAD:  pad_in = csr_pwdata[PAD_W-1:0];
                  default:  ;
               endcase
            end
            if (req_acc && (req_chan.req_type == REQ_DATA)) begin
               shreg_in  = req_chan.data_byte;
               fin_in    = req_chan.final_byte;
               mode_b_in = 1'b0;
               bits_in   = req_chan.final_byte ?
                           (CNT_W'(BYTE_BITS) - {1'b0, pad_ff}) : CNT_W'(BYTE_BITS);
               state_in  = ST_WALK;
            end
         end
         ST_WALK: begin
            if (!stall) begin
               // move one edge down the tree
               if (step) begin
                  cur_in    = shreg_ff[7] ? entry.child_r : entry.child_l;
                  shreg_in  = {shreg_ff[6:0], 1'b0};
                  bits_in   = bits_ff - CNT_W'(1);
                  mode_b_in = 1'b1;
               end
               // leaf reached: queue its symbol, back to the root
               if (emit) begin
                  if (hold_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_sym_in   = hold_sym_ff;
                     rsp_last_in  = 1'b0;
                  end
                  hold_in     = 1'b1;
                  hold_sym_in = entry.sym;
                  cur_in      = root_ff;
                  mode_b_in   = 1'b0;
                  // a leaf seen at the start of a bit uses up that bit
                  if (!mode_b_ff) begin
                     shreg_in = {shreg_ff[6:0], 1'b0};
                     bits_in  = bits_ff - CNT_W'(1);
                  end
               end
               // end of byte: release the held symbol as last of the run
               if (finish) begin
                  if (hold_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_sym_in   = hold_sym_ff;
                     rsp_last_in  = 1'b1;
                  end
                  hold_in   = 1'b0;
                  mode_b_in = 1'b0;
                  if (fin_ff) begin
                     cur_in = root_ff;
                  end
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cur_ff       <= '0;
         mode_b_ff    <= 1'b0;
         bits_ff      <= '0;
         fin_ff       <= 1'b0;
         hold_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         root_ff      <= '0;
         pad_ff       <= '0;
         oor_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_ff       <= cur_in;
         mode_b_ff    <= mode_b_in;
         bits_ff      <= bits_in;
         fin_ff       <= fin_in;
         hold_ff      <= hold_in;
         rsp_valid_ff <= rsp_valid_in;
         root_ff      <= root_in;
         pad_ff       <= pad_in;
         oor_ff       <= oor_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      shreg_ff    <= shreg_in;
      hold_sym_ff <= hold_sym_in;
      rsp_sym_ff  <= rsp_sym_in;
      rsp_last_ff <= rsp_last_in;
   end

   // result channel
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.symbol      = rsp_sym_ff;
   assign rsp_chan.last_of_run = rsp_last_ff;

endmodule
